// ===== hw/rtl/calclk_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar clock core.
package calclk_pkg;

   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } calclk_cmd_type;

   typedef struct packed {
      calclk_cmd_type cmd;
      logic [7:0]     set_year;
      logic [7:0]     set_month_bcd;
      logic [7:0]     set_day_bcd;
      logic [7:0]     set_hours_bcd;
      logic [7:0]     set_minutes_bcd;
      logic [7:0]     set_seconds_bcd;
      logic [7:0]     set_tenths;
   } calclk_req_type;

   typedef struct packed {
      logic [7:0] seconds_now;
      logic [7:0] minutes_now;
      logic [7:0] hours_now;
      logic [7:0] day_now;
      logic [7:0] month_now;
      logic [7:0] year_now;
      logic [3:0] tenths_now;
   } calclk_rsp_type;

   typedef struct packed {
      logic           valid;
      calclk_req_type req;
   } calclk_stage_type;

   localparam logic [7:0] SEC_WRAP        = 8'd60;
   localparam logic [7:0] MIN_WRAP        = 8'd60;
   localparam logic [7:0] HOUR_WRAP       = 8'd24;
   localparam logic [7:0] MONTH_LAST      = 8'd12;
   localparam logic [7:0] MONTH_FEB       = 8'd2;
   localparam logic [7:0] DAY_FIRST       = 8'd1;
   localparam logic [7:0] MONTH_FIRST     = 8'd1;
   localparam logic [7:0] LONG_MONTH      = 8'd31;
   localparam logic [7:0] FEB_SHORT       = 8'd28;
   localparam logic [7:0] MONTH_TENS_MASK = 8'h10;
   localparam logic [7:0] DAY_TENS_MASK   = 8'h30;
   localparam logic [7:0] TIME_TENS_MASK  = 8'hF0;
   localparam logic [7:0] UNITS_MASK      = 8'h0F;
   // year offsets of 1900 and 2100: century years that are not leap years
   localparam logic [7:0] YEAR_1900       = 8'd0;
   localparam logic [7:0] YEAR_2100       = 8'd200;

   localparam logic [7:0] MONTH_LEN [12] = '{
      8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
      8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
   };

   // full year 1900..2155: multiple of 4 unless 1900 or 2100
   function automatic logic leap_of(input logic [7:0] yr);
      return (yr[1:0] == 2'b00) && (yr != YEAR_1900) && (yr != YEAR_2100);
   endfunction

   function automatic logic [7:0] days_in(input logic [7:0] m, input logic leap);
      logic [3:0] idx;
      idx = 4'(m - 8'd1);
      if ((m == 8'd0) || (m > MONTH_LAST)) begin
         return LONG_MONTH;
      end else if (m == MONTH_FEB) begin
         return FEB_SHORT + {7'd0, leap};
      end else begin
         return MONTH_LEN[idx];
      end
   endfunction

   function automatic logic [7:0] bcd_value(input logic [7:0] b, input logic [7:0] tens_mask);
      logic [7:0] masked;
      logic [7:0] tens;
      masked = b & tens_mask;
      tens   = {4'd0, masked[7:4]};
      return (tens << 3) + (tens << 1) + (b & UNITS_MASK);
   endfunction

endpackage

// ===== hw/rtl/calclk_in_reg.sv =====
// Input register stage that captures requests and holds them while the update stage stalls.
module calclk_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  calclk_pkg::calclk_req_type req_data,
   input  logic                       ready,
   output calclk_pkg::calclk_stage_type stage
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   calclk_pkg::calclk_req_type in_req_ff;
   logic                       accept;

   assign req_stall   = in_valid_ff && !ready;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (ready ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_data;
      end
   end

   assign stage.valid = in_valid_ff;
   assign stage.req   = in_req_ff;

endmodule

// ===== hw/rtl/calclk_update.sv =====
// Calendar state registers, tick cascade and BCD load, and the result register.
module calclk_update (
   input  logic                         clock,
   input  logic                         reset,
   input  calclk_pkg::calclk_stage_type stage,
   output logic                         ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output calclk_pkg::calclk_rsp_type   rsp_data
);

   logic [7:0] sec_count_ff,   sec_count_in;
   logic [7:0] min_count_ff,   min_count_in;
   logic [7:0] hour_count_ff,  hour_count_in;
   logic [7:0] day_count_ff,   day_count_in;
   logic [7:0] month_count_ff, month_count_in;
   logic [7:0] year_count_ff,  year_count_in;
   logic [3:0] tenths_ff,      tenths_in;
   logic       feb_leap_ff,    feb_leap_in;
   logic       rsp_valid_ff,   rsp_valid_in;
   calclk_pkg::calclk_rsp_type rsp_data_ff, rsp_data_in;

   logic       take;
   logic [7:0] sec_inc, min_inc, hour_inc, day_inc, month_inc, year_inc;

   assign ready = !rsp_valid_ff || !rsp_stall;
   assign take  = stage.valid && ready;

   assign sec_inc   = sec_count_ff + 8'd1;
   assign min_inc   = min_count_ff + 8'd1;
   assign hour_inc  = hour_count_ff + 8'd1;
   assign day_inc   = day_count_ff + 8'd1;
   assign month_inc = month_count_ff + 8'd1;
   assign year_inc  = year_count_ff + 8'd1;

   always_comb begin
      sec_count_in   = sec_count_ff;
      min_count_in   = min_count_ff;
      hour_count_in  = hour_count_ff;
      day_count_in   = day_count_ff;
      month_count_in = month_count_ff;
      year_count_in  = year_count_ff;
      tenths_in      = tenths_ff;
      feb_leap_in    = feb_leap_ff;
      if (take) begin
         unique case (stage.req.cmd)
            calclk_pkg::CMD_SET: begin
               year_count_in  = stage.req.set_year;
               month_count_in = calclk_pkg::bcd_value(stage.req.set_month_bcd,
                                                      calclk_pkg::MONTH_TENS_MASK);
               day_count_in   = calclk_pkg::bcd_value(stage.req.set_day_bcd,
                                                      calclk_pkg::DAY_TENS_MASK);
               hour_count_in  = calclk_pkg::bcd_value(stage.req.set_hours_bcd,
                                                      calclk_pkg::TIME_TENS_MASK);
               min_count_in   = calclk_pkg::bcd_value(stage.req.set_minutes_bcd,
                                                      calclk_pkg::TIME_TENS_MASK);
               sec_count_in   = calclk_pkg::bcd_value(stage.req.set_seconds_bcd,
                                                      calclk_pkg::TIME_TENS_MASK);
               tenths_in      = stage.req.set_tenths[3:0];
               feb_leap_in    = calclk_pkg::leap_of(stage.req.set_year);
            end
            calclk_pkg::CMD_TICK: begin
               if (sec_inc < calclk_pkg::SEC_WRAP) begin
                  sec_count_in = sec_inc;
               end else begin
                  sec_count_in = '0;
                  if (min_inc != calclk_pkg::MIN_WRAP) begin
                     min_count_in = min_inc;
                  end else begin
                     min_count_in = '0;
                     if (hour_inc != calclk_pkg::HOUR_WRAP) begin
                        hour_count_in = hour_inc;
                     end else begin
                        hour_count_in = '0;
                        if (day_inc <= calclk_pkg::days_in(month_count_ff, feb_leap_ff)) begin
                           day_count_in = day_inc;
                        end else begin
                           day_count_in = calclk_pkg::DAY_FIRST;
                           if (month_inc <= calclk_pkg::MONTH_LAST) begin
                              month_count_in = month_inc;
                           end else begin
                              month_count_in = calclk_pkg::MONTH_FIRST;
                              year_count_in  = year_inc;
                              feb_leap_in    = calclk_pkg::leap_of(year_inc);
                           end
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid_in            = take ? 1'b1 : (ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in.seconds_now = sec_count_in;
   assign rsp_data_in.minutes_now = min_count_in;
   assign rsp_data_in.hours_now   = hour_count_in;
   assign rsp_data_in.day_now     = day_count_in;
   assign rsp_data_in.month_now   = month_count_in;
   assign rsp_data_in.year_now    = year_count_in;
   assign rsp_data_in.tenths_now  = tenths_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_count_ff   <= '0;
         min_count_ff   <= '0;
         hour_count_ff  <= '0;
         day_count_ff   <= calclk_pkg::DAY_FIRST;
         month_count_ff <= calclk_pkg::MONTH_FIRST;
         year_count_ff  <= '0;
         tenths_ff      <= '0;
         feb_leap_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sec_count_ff   <= sec_count_in;
         min_count_ff   <= min_count_in;
         hour_count_ff  <= hour_count_in;
         day_count_ff   <= day_count_in;
         month_count_ff <= month_count_in;
         year_count_ff  <= year_count_in;
         tenths_ff      <= tenths_in;
         feb_leap_ff    <= feb_leap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/calendar_clock_with_bcd_set_core.sv =====
// Top level of the calendar clock core: input register followed by the calendar update stage.
// Each request (a one-second tick or a BCD time set) yields exactly one response showing the
// time after that request. A request is registered on entry, and the calendar update writes
// its result into the response register, so a response passes through both registers. A new
// request can be taken every cycle while rsp_stall is low; the read-modify-write of the
// calendar state sets that rate. Response stall backs up through both registers to req_stall.
module calendar_clock_with_bcd_set_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  calclk_pkg::calclk_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output calclk_pkg::calclk_rsp_type rsp_data
);

   calclk_pkg::calclk_stage_type stage;
   logic                         ready;

   calclk_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ready     (ready),
      .stage     (stage)
   );

   calclk_update u_update (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/calclk_checker.sv =====
// Port-level assertions for the calendar clock core and the bind that attaches them.
module calclk_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input calclk_pkg::calclk_req_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input calclk_pkg::calclk_rsp_type rsp_data
);

   logic [7:0] month_max;
   logic [7:0] day_max;
   logic [7:0] sec_max;

   assign month_max = 8'd25;
   assign day_max   = 8'd45;
   assign sec_max   = 8'd165;

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
      else $error("stalled request changed");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   a_date_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.month_now <= month_max) && (rsp_data.day_now <= day_max)))
      else $error("date out of reachable range");

   a_sec_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.seconds_now <= sec_max))
      else $error("seconds out of reachable range");

endmodule

bind calendar_clock_with_bcd_set_core calclk_checker u_calclk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
